// ----- hdl/cdws_pkg.sv -----
// ----------------------------------------------------------------------------
// cdws_pkg
// Shared types and fixed constants of the calibrated DAC write sequencer.
// ----------------------------------------------------------------------------
package cdws_pkg;

    // Item function codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_LEVEL = 1'b1;

    // Bus transaction constants
    localparam logic [6:0] MUX_BUS_ADDR  = 7'h70;
    localparam logic [7:0] MUX_CTRL_BASE = 8'h04;
    localparam logic [6:0] DAC_BUS_BASE  = 7'h4c;
    localparam logic [7:0] DAC_CTRL_BASE = 8'h10;
    localparam logic [1:0] MUX_BYTES     = 2'd1;
    localparam logic [1:0] DAC_BYTES     = 2'd3;
    localparam logic [1:0] MUX_NONE      = 2'd3;

    // Fields of a tube ROM word
    localparam int ROM_MUX_BIT = 4;
    localparam logic [4:0] ROM_DEV_MASK = 5'b01100;
    localparam logic [4:0] ROM_CH_MASK  = 5'h03;

    // Memory controls from the sequencer to the store
    typedef struct packed {
        logic cal_we;
        logic cache_we;
        logic rd_en;
    } cdws_mem_ctl_t;

    // Tube to mux channel / DAC device / DAC channel map
    function automatic logic [4:0] tube_rom(input logic [4:0] tube);
        logic [4:0] rom;
        case (tube)
            5'd0:    rom = 5'h0c;
            5'd1:    rom = 5'h0e;
            5'd2:    rom = 5'h0d;
            5'd3:    rom = 5'h0f;
            5'd4:    rom = 5'h04;
            5'd5:    rom = 5'h06;
            5'd6:    rom = 5'h05;
            5'd7:    rom = 5'h07;
            5'd8:    rom = 5'h08;
            5'd9:    rom = 5'h0a;
            5'd10:   rom = 5'h09;
            5'd11:   rom = 5'h0b;
            5'd12:   rom = 5'h18;
            5'd13:   rom = 5'h1a;
            5'd14:   rom = 5'h19;
            5'd15:   rom = 5'h1b;
            5'd16:   rom = 5'h14;
            5'd17:   rom = 5'h16;
            5'd18:   rom = 5'h15;
            5'd19:   rom = 5'h17;
            5'd20:   rom = 5'h1c;
            5'd21:   rom = 5'h1e;
            5'd22:   rom = 5'h1d;
            5'd23:   rom = 5'h1f;
            default: rom = 5'h0c;
        endcase
        return rom;
    endfunction

endpackage

// ----- hdl/cdws_in_if.sv -----
// ----------------------------------------------------------------------------
// cdws_in_if
// Input item channel: calibration loads and tube level requests.
// ----------------------------------------------------------------------------
interface cdws_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [4:0]  tube;
    logic [2:0]  point;
    logic [7:0]  cal_value;
    logic [16:0] level;

    modport source (
        output valid, func, tube, point, cal_value, level,
        input  ready
    );
    modport sink (
        input  valid, func, tube, point, cal_value, level,
        output ready
    );
endinterface

// ----- hdl/cdws_out_if.sv -----
// ----------------------------------------------------------------------------
// cdws_out_if
// Result channel: one bus write transaction per beat.
// ----------------------------------------------------------------------------
interface cdws_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] bus_address;
    logic [1:0] byte_count;
    logic [7:0] data_byte0;
    logic [7:0] data_byte1;
    logic [7:0] data_byte2;
    logic       last;

    modport source (
        output valid, bus_address, byte_count, data_byte0, data_byte1,
               data_byte2, last,
        input  ready
    );
    modport sink (
        input  valid, bus_address, byte_count, data_byte0, data_byte1,
               data_byte2, last,
        output ready
    );
endinterface

// ----- hdl/cdws_store.sv -----
// ----------------------------------------------------------------------------
// cdws_store
// Calibration memory (two read ports) and code cache, with a clearing pass
// after reset.
// ----------------------------------------------------------------------------
module cdws_store #(
    parameter int TUBE_COUNT = 24,
    parameter int CAL_POINTS = 8,
    parameter int DEPTH      = TUBE_COUNT * CAL_POINTS,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdws_pkg::cdws_mem_ctl_t ctl,
    input  logic [AW-1:0]          cal_waddr,
    input  logic [7:0]             cal_wdata,
    input  logic [AW-1:0]          rd_addr_a,
    input  logic [AW-1:0]          rd_addr_b,
    input  logic [CW-1:0]          cache_addr,
    input  logic [7:0]             cache_wdata,
    output logic [7:0]             rd_data_a,
    output logic [7:0]             rd_data_b,
    output logic [7:0]             cache_rdata,
    output logic                   clear_done
);
    import cdws_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [7:0] cal_mem [DEPTH];
    logic [7:0] cache_mem [TUBE_COUNT];

    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;

    logic          cal_we;
    logic [AW-1:0] cal_wa;
    logic [7:0]    cal_wd;
    logic          cache_we;
    logic [CW-1:0] cache_wa;
    logic [7:0]    cache_wd;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            if (clr_cnt_reg == LAST_ADDR)
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // The sweep owns both write ports while it runs
    always_comb
    begin
        if (clr_busy_reg)
        begin
            cal_we   = 1'b1;
            cal_wa   = clr_cnt_reg;
            cal_wd   = '0;
            cache_we = (32'(clr_cnt_reg) < TUBE_COUNT);
            cache_wa = CW'(clr_cnt_reg);
            cache_wd = '0;
        end
        else
        begin
            cal_we   = ctl.cal_we;
            cal_wa   = cal_waddr;
            cal_wd   = cal_wdata;
            cache_we = ctl.cache_we;
            cache_wa = cache_addr;
            cache_wd = cache_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cal_we)
        begin
            cal_mem[cal_wa] <= cal_wd;
        end
        if (ctl.rd_en)
        begin
            rd_data_a <= cal_mem[rd_addr_a];
            rd_data_b <= cal_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cache_we)
        begin
            cache_mem[cache_wa] <= cache_wd;
        end
        if (ctl.rd_en)
        begin
            cache_rdata <= cache_mem[cache_addr];
        end
    end

    assign clear_done = !clr_busy_reg;

endmodule

// ----- hdl/cdws_seq.sv -----
// ----------------------------------------------------------------------------
// cdws_seq
// Item sequencer: decodes items, interpolates the calibration points,
// checks the code cache and emits the mux and DAC bus beats.
// ----------------------------------------------------------------------------
module cdws_seq #(
    parameter int TUBE_COUNT = 24,
    parameter int CAL_POINTS = 8,
    parameter int DEPTH      = TUBE_COUNT * CAL_POINTS,
    parameter int AW         = $clog2(DEPTH),
    parameter int CW         = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1,
    parameter int PW         = $clog2(CAL_POINTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    cdws_in_if.sink                 req,
    cdws_out_if.source              txn,
    input  logic                    clear_done,
    input  logic [7:0]              rd_data_a,
    input  logic [7:0]              rd_data_b,
    input  logic [7:0]              cache_rdata,
    output cdws_pkg::cdws_mem_ctl_t ctl,
    output logic [AW-1:0]           cal_waddr,
    output logic [7:0]              cal_wdata,
    output logic [AW-1:0]           rd_addr_a,
    output logic [AW-1:0]           rd_addr_b,
    output logic [CW-1:0]           cache_addr,
    output logic [7:0]              cache_wdata
);
    import cdws_pkg::*;

    localparam int TW = 16 + PW;
    localparam logic [PW-1:0] LAST_PT     = PW'(CAL_POINTS - 1);
    localparam logic [AW-1:0] CAL_POINTS_W = AW'(CAL_POINTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MATH = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_DAC  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    mux_reg, mux_next;
    logic [4:0]    tube_reg, tube_next;
    logic [PW-1:0] idx_a_reg, idx_a_next;
    logic [PW-1:0] idx_b_reg, idx_b_next;
    logic [15:0]   frac_reg, frac_next;
    logic [7:0]    code_reg, code_next;

    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_addr_reg, out_addr_next;
    logic [1:0] out_cnt_reg, out_cnt_next;
    logic [7:0] out_b0_reg, out_b0_next;
    logic [7:0] out_b1_reg, out_b1_next;
    logic       out_last_reg, out_last_next;

    logic          accept;
    logic          tube_ok;
    logic [TW-1:0] scaled;
    logic [4:0]    rom;
    logic          rom_ch;
    logic          out_free;
    logic [AW-1:0] base;
    logic signed [8:0]  diff;
    logic signed [25:0] prod;
    logic signed [25:0] sum;

    assign req.ready = (state_reg == S_IDLE) && clear_done;
    assign accept    = req.valid && req.ready;
    assign tube_ok   = (32'(req.tube) < TUBE_COUNT);

    // level * (points - 1): integer part picks the segment, rest is the weight
    assign scaled = TW'(req.level[15:0]) * TW'(LAST_PT);

    assign cal_waddr = AW'(req.tube) * CAL_POINTS_W + AW'(req.point);
    assign cal_wdata = req.cal_value;

    assign base       = AW'(tube_reg) * CAL_POINTS_W;
    assign rd_addr_a  = base + AW'(idx_a_reg);
    assign rd_addr_b  = base + AW'(idx_b_reg);
    assign cache_addr = CW'(tube_reg);
    assign cache_wdata = code_reg;

    assign rom    = tube_rom(tube_reg);
    assign rom_ch = rom[ROM_MUX_BIT];

    // a + ((b - a) * f) >> 16, floored
    assign diff = $signed({1'b0, rd_data_b}) - $signed({1'b0, rd_data_a});
    assign prod = 26'(diff * $signed({1'b0, frac_reg}));
    assign sum  = $signed({2'b00, rd_data_a, 16'h0000}) + prod;

    assign out_free = !out_valid_reg || txn.ready;

    always_comb
    begin
        state_next     = state_reg;
        mux_next       = mux_reg;
        tube_next      = tube_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        frac_next      = frac_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && !txn.ready;
        out_addr_next  = out_addr_reg;
        out_cnt_next   = out_cnt_reg;
        out_b0_next    = out_b0_reg;
        out_b1_next    = out_b1_reg;
        out_last_next  = out_last_reg;
        ctl            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && tube_ok)
                begin
                    if (req.func == FUNC_LOAD)
                    begin
                        ctl.cal_we = (32'(req.point) < CAL_POINTS);
                    end
                    else
                    begin
                        tube_next = req.tube;
                        if (req.level[16])
                        begin
                            idx_a_next = LAST_PT;
                            idx_b_next = LAST_PT;
                            frac_next  = '0;
                        end
                        else
                        begin
                            idx_a_next = scaled[TW-1:16];
                            idx_b_next = scaled[TW-1:16] + 1'b1;
                            frac_next  = scaled[15:0];
                        end
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                ctl.rd_en  = 1'b1;
                state_next = S_MATH;
            end
            S_MATH:
            begin
                code_next  = sum[23:16];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (code_reg == cache_rdata)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    ctl.cache_we   = 1'b1;
                    out_valid_next = 1'b1;
                    if ({1'b0, rom_ch} != mux_reg)
                    begin
                        mux_next      = {1'b0, rom_ch};
                        out_addr_next = MUX_BUS_ADDR;
                        out_cnt_next  = MUX_BYTES;
                        out_b0_next   = MUX_CTRL_BASE + {7'b0, rom_ch};
                        out_b1_next   = '0;
                        out_last_next = 1'b0;
                        state_next    = S_DAC;
                    end
                    else
                    begin
                        out_addr_next = DAC_BUS_BASE + {5'b0, rom[3:2]};
                        out_cnt_next  = DAC_BYTES;
                        out_b0_next   = DAC_CTRL_BASE + {5'b0, rom[1:0], 1'b0};
                        out_b1_next   = code_reg;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_DAC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = DAC_BUS_BASE + {5'b0, rom[3:2]};
                    out_cnt_next   = DAC_BYTES;
                    out_b0_next    = DAC_CTRL_BASE + {5'b0, rom[1:0], 1'b0};
                    out_b1_next    = code_reg;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mux_reg       <= MUX_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mux_reg       <= mux_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tube_reg     <= tube_next;
        idx_a_reg    <= idx_a_next;
        idx_b_reg    <= idx_b_next;
        frac_reg     <= frac_next;
        code_reg     <= code_next;
        out_addr_reg <= out_addr_next;
        out_cnt_reg  <= out_cnt_next;
        out_b0_reg   <= out_b0_next;
        out_b1_reg   <= out_b1_next;
        out_last_reg <= out_last_next;
    end

    assign txn.valid       = out_valid_reg;
    assign txn.bus_address = out_addr_reg;
    assign txn.byte_count  = out_cnt_reg;
    assign txn.data_byte0  = out_b0_reg;
    assign txn.data_byte1  = out_b1_reg;
    assign txn.data_byte2  = '0;
    assign txn.last        = out_last_reg;

endmodule

// ----- hdl/calibrated_dac_write_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// calibrated_dac_write_sequencer_top
// Maps tube level requests through per-tube calibration points to DAC codes
// and issues mux select and DAC write bus beats when a code changes.
// ----------------------------------------------------------------------------
//  channel | dir | beat
//  --------+-----+-----------------------------------------------------------
//  req     | in  | func, tube, point, cal_value, level
//  txn     | out | bus_address, byte_count, data_byte0..2, last
//
//  A load beat is written on acceptance; req is ready again the next cycle.
//  A level beat passes through the read, interpolate and compare/emit states,
//  plus a DAC state when a mux select beat goes out first.
//  After reset a clearing pass over all TUBE_COUNT*CAL_POINTS entries holds req low.
//  A stalled txn holds the sequencer in its emit or DAC state; a waiting result
//  sits in the output register while the next req beat is taken.
// ----------------------------------------------------------------------------
module calibrated_dac_write_sequencer_top #(
    parameter int TUBE_COUNT = 24,
    parameter int CAL_POINTS = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    cdws_in_if.sink    req,
    cdws_out_if.source txn
);
    import cdws_pkg::*;

    localparam int DEPTH = TUBE_COUNT * CAL_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
    localparam int PW    = $clog2(CAL_POINTS);

    cdws_mem_ctl_t ctl;
    logic [AW-1:0] cal_waddr;
    logic [7:0]    cal_wdata;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [CW-1:0] cache_addr;
    logic [7:0]    cache_wdata;
    logic [7:0]    rd_data_a;
    logic [7:0]    rd_data_b;
    logic [7:0]    cache_rdata;
    logic          clear_done;

    cdws_store #(
        .TUBE_COUNT (TUBE_COUNT),
        .CAL_POINTS (CAL_POINTS),
        .DEPTH      (DEPTH),
        .AW         (AW),
        .CW         (CW)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .cal_waddr   (cal_waddr),
        .cal_wdata   (cal_wdata),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .cache_addr  (cache_addr),
        .cache_wdata (cache_wdata),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .cache_rdata (cache_rdata),
        .clear_done  (clear_done)
    );

    cdws_seq #(
        .TUBE_COUNT (TUBE_COUNT),
        .CAL_POINTS (CAL_POINTS),
        .DEPTH      (DEPTH),
        .AW         (AW),
        .CW         (CW),
        .PW         (PW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .txn         (txn),
        .clear_done  (clear_done),
        .rd_data_a   (rd_data_a),
        .rd_data_b   (rd_data_b),
        .cache_rdata (cache_rdata),
        .ctl         (ctl),
        .cal_waddr   (cal_waddr),
        .cal_wdata   (cal_wdata),
        .rd_addr_a   (rd_addr_a),
        .rd_addr_b   (rd_addr_b),
        .cache_addr  (cache_addr),
        .cache_wdata (cache_wdata)
    );

endmodule
